/* rtl/itra_pkg.sv */
// Shared types, constants and the digit-to-ASCII function for the radix text converter.
// Used by the channel interfaces and by every module under rtl/.
package itra_pkg;

    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 6;
    localparam int BUF_W       = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int CFG_DATA_W  = 8;
    localparam int MAX_DIGITS  = 32;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int FIT_W       = ((CNT_W > BUF_W) ? CNT_W : BUF_W) + 1;
    localparam int CHUNK_W     = 8;
    localparam int N_CHUNKS    = VALUE_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(N_CHUNKS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BUF_W-1:0]   BUF_MIN     = 8'd2;
    localparam logic [BUF_W-1:0]   BUF_RESET   = 8'd10;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [DIGIT_W-1:0] DIGIT_TOP = 6'd35;

    typedef enum logic [0:0] {
        REG_RADIX         = 1'b0,
        REG_BUFFER_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               bad;
    } t_job;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [BUF_W-1:0]   buffer_length;
    } t_cfg;

    // Map a digit value to 0-9 a-z; anything past 'z' clamps to 'z'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d <= DIGIT_TOP) begin
            c = CHAR_LOW_A + CHAR_W'(d - 6'd10);
        end else begin
            c = CHAR_LOW_Z;
        end
        return c;
    endfunction

endpackage

/* rtl/itra_if.sv */
// Valid/ready channel interfaces of the radix text converter: input, result and config write.
// Depends on itra_pkg for widths and the register index type.
interface itra_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [itra_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itra_out_if;
    logic                        valid;
    logic                        ready;
    logic [itra_pkg::CHAR_W-1:0] character;
    logic                        last;
    logic                        error;

    modport source (output valid, output character, output last, output error, input ready);
    modport sink   (input valid, input character, input last, input error, output ready);
endinterface

interface itra_cfg_if;
    logic                            valid;
    logic                            ready;
    itra_pkg::t_reg_idx              index;
    logic [itra_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/itra_front.sv */
// Front end: configuration registers, input acceptance, sign/magnitude split and config check.
// Depends on itra_pkg and itra_if.
module itra_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    itra_in_if.sink        i_in,
    itra_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output itra_pkg::t_job o_job,
    output itra_pkg::t_cfg o_cfg
);

    logic [itra_pkg::RADIX_W-1:0] r_radix;
    logic [itra_pkg::BUF_W-1:0]   r_buffer_length;
    logic [itra_pkg::VALUE_W-1:0] w_raw;
    logic                         w_neg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix         <= itra_pkg::RADIX_RESET;
            r_buffer_length <= itra_pkg::BUF_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                itra_pkg::REG_RADIX:         r_radix <= i_cfg.data[itra_pkg::RADIX_W-1:0];
                itra_pkg::REG_BUFFER_LENGTH: r_buffer_length <= i_cfg.data[itra_pkg::BUF_W-1:0];
                default:                     r_radix <= r_radix;
            endcase
        end
    end

    assign w_raw = i_in.value;
    assign w_neg = w_raw[itra_pkg::VALUE_W-1];

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Negate as unsigned so the most negative value keeps its full magnitude.
    assign o_job.mag = w_neg ? (itra_pkg::VALUE_W'(0) - w_raw) : w_raw;
    assign o_job.neg = w_neg;
    assign o_job.bad = (r_radix < itra_pkg::RADIX_MIN) || (r_radix > itra_pkg::RADIX_MAX)
                    || (r_buffer_length < itra_pkg::BUF_MIN);

    assign o_cfg.radix         = r_radix;
    assign o_cfg.buffer_length = r_buffer_length;

endmodule

/* rtl/itra_queue.sv */
// Short job queue between the front end and the conversion engine.
// Depends on itra_pkg for the job type and depth.
module itra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itra_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output itra_pkg::t_job o_job,
    output logic           o_empty
);

    itra_pkg::t_job              r_slots [itra_pkg::QUEUE_DEPTH];
    logic [itra_pkg::QPTR_W-1:0] r_wptr;
    logic [itra_pkg::QPTR_W-1:0] r_rptr;
    logic [itra_pkg::QCNT_W-1:0] r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_full  = (r_count == itra_pkg::QCNT_W'(itra_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_slots[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == itra_pkg::QPTR_W'(itra_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == itra_pkg::QPTR_W'(itra_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/itra_back.sv */
// Conversion engine: chunked long division into the digit store, fit check, character output.
// Depends on itra_pkg and itra_if.
module itra_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itra_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  itra_pkg::t_job i_job,
    output logic           o_pop,
    itra_out_if.source     o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_ERR,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic [itra_pkg::VALUE_W-1:0]     r_q;
    logic [itra_pkg::DIGIT_W-1:0]     r_rem;
    logic [itra_pkg::CHUNK_CNT_W-1:0] r_chunk;
    logic [itra_pkg::CNT_W-1:0]       r_n;
    logic                             r_neg;
    logic [itra_pkg::DIGIT_W-1:0]     r_digits [itra_pkg::MAX_DIGITS];
    logic [itra_pkg::DIGIT_W-1:0]     r_rd_digit;
    logic                             r_out_valid;
    logic [itra_pkg::CHAR_W-1:0]      r_out_char;
    logic                             r_out_last;
    logic                             r_out_error;

    logic [itra_pkg::DIGIT_W-1:0]     w_rem;
    logic [itra_pkg::DIGIT_W:0]       w_trial;
    logic [itra_pkg::CHUNK_W-1:0]     w_qbits;
    logic [itra_pkg::VALUE_W-1:0]     w_q_next;
    logic                             w_last_chunk;
    logic [itra_pkg::CNT_W-1:0]       w_n_inc;
    logic [itra_pkg::CNT_W-1:0]       w_n_dec;
    logic [itra_pkg::FIT_W-1:0]       w_need;
    logic                             w_out_free;
    logic                             w_out_load;
    logic                             w_we;
    logic                             w_re;

    // Eight restoring-division steps per cycle on the top bits of the dividend.
    always_comb begin
        w_rem   = r_rem;
        w_trial = '0;
        w_qbits = '0;
        for (int i = 0; i < itra_pkg::CHUNK_W; i++) begin
            w_trial = {w_rem, r_q[itra_pkg::VALUE_W-1-i]};
            if (w_trial >= {1'b0, i_cfg.radix}) begin
                w_rem = itra_pkg::DIGIT_W'(w_trial - {1'b0, i_cfg.radix});
                w_qbits[itra_pkg::CHUNK_W-1-i] = 1'b1;
            end else begin
                w_rem = w_trial[itra_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign w_q_next     = {r_q[itra_pkg::VALUE_W-itra_pkg::CHUNK_W-1:0], w_qbits};
    assign w_last_chunk = (r_chunk == itra_pkg::CHUNK_CNT_W'(itra_pkg::N_CHUNKS - 1));
    assign w_n_inc      = r_n + 1'b1;
    assign w_n_dec      = r_n - 1'b1;
    assign w_need       = itra_pkg::FIT_W'(r_n) + itra_pkg::FIT_W'(r_neg) + 1'b1;
    assign w_out_free   = !r_out_valid || o_out.ready;
    // a new word enters the output register this cycle
    assign w_out_load   = w_out_free
                       && (r_state == S_ERR || r_state == S_SIGN || r_state == S_EMIT);
    assign w_we         = (r_state == S_DIV) && w_last_chunk;
    assign w_re         = (r_state == S_READ);
    assign o_pop        = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_digits[r_n[itra_pkg::ADDR_W-1:0]] <= w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_digit <= r_digits[w_n_dec[itra_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_q     <= i_job.mag;
                        r_neg   <= i_job.neg;
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_n     <= '0;
                        r_state <= i_job.bad ? S_ERR : S_DIV;
                    end
                end
                S_DIV: begin
                    r_q     <= w_q_next;
                    r_rem   <= w_rem;
                    r_chunk <= r_chunk + 1'b1;
                    if (w_last_chunk) begin
                        r_rem <= '0;
                        r_n   <= w_n_inc;
                        if (w_q_next == '0) begin
                            r_state <= S_CHECK;
                        end else if (w_n_inc >= itra_pkg::CNT_W'(itra_pkg::MAX_DIGITS)) begin
                            // more digits than the store holds
                            r_state <= S_ERR;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_need > itra_pkg::FIT_W'(i_cfg.buffer_length)) begin
                        r_state <= S_ERR;
                    end else if (r_neg) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itra_pkg::CHAR_NUL;
                        r_out_last  <= 1'b1;
                        r_out_error <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itra_pkg::CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_out_error <= 1'b0;
                        r_state     <= S_READ;
                    end
                end
                S_READ: begin
                    r_n     <= w_n_dec;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itra_pkg::digit_char(r_rd_digit);
                        r_out_last  <= (r_n == '0);
                        r_out_error <= 1'b0;
                        r_state     <= (r_n == '0) ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;
    assign o_out.error     = r_out_error;

endmodule

/* rtl/integer_to_radix_ascii_top.sv */
// Top level of the radix text converter: front end, job queue and conversion engine.
// Depends on itra_pkg, itra_if, itra_front, itra_queue and itra_back.
//
// Converts a signed 32-bit word to its text in radix 2..36 (digits 0-9 a-z, leading '-' when
// negative), one character per output word, most significant first, last set on the final
// character. A radix outside 2..36, a buffer_length below 2, or text that with its terminator
// would not fit in buffer_length gives one word with character 0, last 1 and error 1. The
// engine takes the job from the queue, the shared divider retires 8 dividend bits per cycle,
// working through the dividend in 8-bit chunks for each digit, then a fit check follows, an
// optional '-' is sent, and each character takes a read of the digit store and then an output
// word; the output register can stall on ready. A two-entry queue lets the input take new words
// while a conversion is running; configuration must be written only while the block is idle.
module integer_to_radix_ascii_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itra_in_if.sink    i_in,
    itra_cfg_if.sink   i_cfg,
    itra_out_if.source o_out
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    itra_pkg::t_job w_job_in;
    itra_pkg::t_job w_job_out;
    itra_pkg::t_cfg w_cfg;

    itra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .o_cfg    (w_cfg)
    );

    itra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    itra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_empty (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the radix text converter: sends signed words, writes radix and buffer_length,
// predicts every character word and checks it. Depends on itra_pkg, itra_if and the RTL top.
module testbench;

    localparam int     RANDOM_ITEMS = 350;
    localparam int     PHASE_ITEMS  = 25;
    localparam longint CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [itra_pkg::CHAR_W-1:0] character;
        logic                        last;
        logic                        error;
    } t_char_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itra_in_if  in_ch();
    itra_cfg_if cfg_ch();
    itra_out_if out_ch();

    integer_to_radix_ascii_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_char_word                   expected_text[$];
    logic [itra_pkg::RADIX_W-1:0] cur_radix;
    logic [itra_pkg::BUF_W-1:0]   cur_buf_len;
    int                           fail_count  = 0;
    int                           send_calm   = 0;
    int                           recv_calm   = 0;
    longint                       cycle_count = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random wait before the next word, with occasional stretches of back-to-back words.
    function automatic int draw_gap(inout int calm_left);
        int gap;
        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(5, 40);
        end else begin
            gap = $urandom_range(0, 18);
        end
        return gap;
    endfunction

    function automatic t_char_word word_of(input logic [itra_pkg::CHAR_W-1:0] ch,
                                           input logic lst, input logic err);
        t_char_word w;
        w.character = ch;
        w.last      = lst;
        w.error     = err;
        return w;
    endfunction

    // Expected text of one value under the current radix and buffer_length.
    task automatic predict_text(input logic [itra_pkg::VALUE_W-1:0] raw);
        logic                         neg;
        logic [itra_pkg::VALUE_W-1:0] quo;
        logic [itra_pkg::DIGIT_W-1:0] digits [itra_pkg::MAX_DIGITS];
        logic [itra_pkg::DIGIT_W-1:0] d;
        int                           n;
        neg = raw[itra_pkg::VALUE_W-1];
        quo = neg ? (32'd0 - raw) : raw;
        n   = 0;
        if (cur_radix < itra_pkg::RADIX_MIN || cur_radix > itra_pkg::RADIX_MAX
                || cur_buf_len < itra_pkg::BUF_MIN) begin
            expected_text.push_back(word_of(itra_pkg::CHAR_NUL, 1'b1, 1'b1));
        end else begin
            do begin
                digits[n] = itra_pkg::DIGIT_W'(quo % cur_radix);
                quo = quo / cur_radix;
                n++;
            end while (quo != 0);
            // digits, sign and terminator must fit the buffer
            if (n + int'(neg) + 1 > int'(cur_buf_len)) begin
                expected_text.push_back(word_of(itra_pkg::CHAR_NUL, 1'b1, 1'b1));
            end else begin
                if (neg) begin
                    expected_text.push_back(word_of(itra_pkg::CHAR_MINUS, 1'b0, 1'b0));
                end
                for (int i = n - 1; i >= 0; i--) begin
                    d = digits[i];
                    expected_text.push_back(word_of(
                        (d < 10) ? itra_pkg::CHAR_ZERO + itra_pkg::CHAR_W'(d)
                                 : itra_pkg::CHAR_LOW_A + itra_pkg::CHAR_W'(d - 10),
                        i == 0, 1'b0));
                end
            end
        end
    endtask

    // Leaves valid high on return so the next word can follow without a gap.
    task automatic send_value(input logic [itra_pkg::VALUE_W-1:0] v);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        predict_text(v);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_text.size() != 0);
    endtask

    task automatic write_reg(input itra_pkg::t_reg_idx idx,
                             input logic [itra_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        if (idx == itra_pkg::REG_RADIX) begin
            cur_radix = data[itra_pkg::RADIX_W-1:0];
        end else begin
            cur_buf_len = data;
        end
    endtask

    task automatic configure(input logic [itra_pkg::CFG_DATA_W-1:0] radix_data,
                             input logic [itra_pkg::CFG_DATA_W-1:0] buf_data);
        wait_idle();
        write_reg(itra_pkg::REG_RADIX, radix_data);
        write_reg(itra_pkg::REG_BUFFER_LENGTH, buf_data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd123456789);
        send_value(32'd1234567890);   // ten digits plus terminator overflow
        send_value(-32'sd12345678);
        send_value(-32'sd123456789);
    endtask

    task automatic test_radix_extremes();
        configure(8'd2, 8'd255);
        send_value(32'd0);
        send_value(32'h7fffffff);
        send_value(32'h80000000);     // magnitude only fits unsigned
        configure(8'd36, 8'd255);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'h7fffffff);
        send_value(32'h80000000);
        // upper data bits above the radix field are dropped
        configure(8'h50, 8'd11);
        send_value(32'hdeadbeef);
        send_value(32'h7abcdef0);
    endtask

    task automatic test_bad_settings();
        configure(8'd0, 8'd10);
        send_value(32'd5);
        configure(8'd1, 8'd10);
        send_value(32'd5);
        configure(8'd37, 8'd10);
        send_value(32'd5);
        configure(8'd63, 8'd255);
        send_value(32'd5);
        configure(8'd10, 8'd0);
        send_value(32'd5);
        configure(8'd10, 8'd1);
        send_value(32'd5);
        // text just fitting and just missing the buffer
        configure(8'd10, 8'd2);
        send_value(32'd7);
        send_value(32'd10);
        send_value(-32'sd7);
        configure(8'd10, 8'd3);
        send_value(-32'sd7);
    endtask

    function automatic logic [itra_pkg::VALUE_W-1:0] random_value();
        logic [itra_pkg::VALUE_W-1:0] v;
        int                           pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            v = $urandom;
        end else if (pick < 14) begin
            v = $urandom_range(0, 1000);
        end else if (pick < 17) begin
            v = $urandom >> $urandom_range(1, 31);
        end else begin
            case ($urandom_range(0, 3))
                0:       v = 32'd0;
                1:       v = 32'h7fffffff;
                2:       v = 32'h80000000;
                default: v = 32'd1;
            endcase
        end
        if (pick >= 8 && pick < 17 && $urandom_range(0, 1) == 1) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    task automatic test_random_phases();
        logic [itra_pkg::CFG_DATA_W-1:0] radix_data;
        logic [itra_pkg::CFG_DATA_W-1:0] buf_data;
        int                              pick;
        int                              sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            radix_data = itra_pkg::CFG_DATA_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                radix_data[itra_pkg::RADIX_W-1:0] = itra_pkg::RADIX_W'($urandom_range(2, 36));
            end else if (pick == 7) begin
                radix_data[itra_pkg::RADIX_W-1:0] = 6'd2;
            end else if (pick == 8) begin
                radix_data[itra_pkg::RADIX_W-1:0] = 6'd36;
            end else begin
                radix_data[itra_pkg::RADIX_W-1:0] = itra_pkg::RADIX_W'(
                    ($urandom_range(0, 1) == 1) ? $urandom_range(37, 63)
                                                : $urandom_range(0, 1));
            end
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                buf_data = itra_pkg::CFG_DATA_W'($urandom_range(34, 255));
            end else if (pick < 16) begin
                buf_data = itra_pkg::CFG_DATA_W'($urandom_range(2, 12));
            end else if (pick == 16) begin
                buf_data = itra_pkg::CFG_DATA_W'($urandom_range(0, 1));
            end else if (pick == 17) begin
                buf_data = 8'd255;
            end else begin
                buf_data = itra_pkg::CFG_DATA_W'($urandom_range(13, 33));
            end
            configure(radix_data, buf_data);
            for (int i = 0; i < PHASE_ITEMS && sent < RANDOM_ITEMS; i++) begin
                send_value(random_value());
                sent++;
            end
        end
    endtask

    initial begin : result_checker
        t_char_word want;
        int         stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(recv_calm);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!out_ch.valid);
            if (expected_text.size() == 0) begin
                $error("unexpected word: character %h last %b error %b",
                       out_ch.character, out_ch.last, out_ch.error);
                fail_count++;
            end else begin
                want = expected_text.pop_front();
                if (out_ch.character !== want.character) begin
                    $error("character: expected %h, got %h", want.character, out_ch.character);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_ch.last);
                    fail_count++;
                end
                if (out_ch.error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, out_ch.error);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= itra_pkg::REG_RADIX;
        cfg_ch.data  <= '0;
        cur_radix    = itra_pkg::RADIX_RESET;
        cur_buf_len  = itra_pkg::BUF_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_radix_extremes();
        test_bad_settings();
        test_random_phases();

        wait_idle();
        // drain: catch any stray words after the last expected one
        repeat (250) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
